>>> design/stun_bp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// STUN binding response parser package
// Types, codes and constants shared by the parser modules.
// ----------------------------------------------------------------------------
package stun_bp_pkg;

	// Default limit on the bytes of one datagram that are parsed.
	localparam int DEFAULT_MAX_DATAGRAM_BYTES = 2048;

	// Header layout.
	localparam int HDR_BYTES = 20;

	// Message types.
	localparam logic [15:0] TYPE_SUCCESS = 16'h0101;
	localparam logic [15:0] TYPE_ERROR   = 16'h0111;

	// Attribute types that are captured.
	localparam logic [15:0] ATTR_MAPPED  = 16'h0001;
	localparam logic [15:0] ATTR_SOURCE  = 16'h0004;
	localparam logic [15:0] ATTR_CHANGED = 16'h0005;

	// Capture slots.
	localparam int SLOT_MAPPED  = 0;
	localparam int SLOT_SOURCE  = 1;
	localparam int SLOT_CHANGED = 2;
	localparam int NUM_SLOTS    = 3;

	// Message kind codes.
	localparam logic [1:0] KIND_SUCCESS = 2'd0;
	localparam logic [1:0] KIND_ERROR   = 2'd1;
	localparam logic [1:0] KIND_OTHER   = 2'd2;
	localparam logic [1:0] KIND_SHORT   = 2'd3;

	// NAT verdict codes.
	localparam logic [1:0] VERDICT_NONE       = 2'd0;
	localparam logic [1:0] VERDICT_FULL_CONE  = 2'd1;
	localparam logic [1:0] VERDICT_RESTRICTED = 2'd2;

	// Configuration port.
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] REG_SERVER_IP   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SERVER_PORT = 1'b1;
	localparam logic [31:0] RESET_SERVER_IP   = 32'h4D48_A9D2;
	localparam logic [15:0] RESET_SERVER_PORT = 16'd3478;

	// One received byte with its datagram's sender.
	typedef struct packed {
		logic [7:0]  rx_byte;
		logic        last_byte;
		logic [31:0] sender_ip;
		logic [15:0] sender_port;
	} item_t;

	// Server address from the configuration registers.
	typedef struct packed {
		logic [31:0] server_ip;
		logic [15:0] server_port;
	} cfg_t;

	// One parse result.
	typedef struct packed {
		logic [1:0]  msg_kind;
		logic        mapped_valid;
		logic [31:0] mapped_ip;
		logic [15:0] mapped_port;
		logic        source_valid;
		logic [31:0] source_attr_ip;
		logic [15:0] source_attr_port;
		logic        changed_valid;
		logic [31:0] changed_ip;
		logic [15:0] changed_port;
		logic [1:0]  nat_verdict;
	} result_t;

endpackage

>>> design/stun_bp_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// STUN parser input channel
// Valid/ready channel that carries one datagram byte and its sender.
// ----------------------------------------------------------------------------
interface stun_bp_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  rx_byte;
	logic        last_byte;
	logic [31:0] sender_ip;
	logic [15:0] sender_port;

	modport source (
		output valid, rx_byte, last_byte, sender_ip, sender_port,
		input  ready
	);
	modport sink (
		input  valid, rx_byte, last_byte, sender_ip, sender_port,
		output ready
	);
endinterface

>>> design/stun_bp_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// STUN parser result channel
// Valid/ready channel that carries one parse result per datagram.
// ----------------------------------------------------------------------------
interface stun_bp_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  msg_kind;
	logic        mapped_valid;
	logic [31:0] mapped_ip;
	logic [15:0] mapped_port;
	logic        source_valid;
	logic [31:0] source_attr_ip;
	logic [15:0] source_attr_port;
	logic        changed_valid;
	logic [31:0] changed_ip;
	logic [15:0] changed_port;
	logic [1:0]  nat_verdict;

	modport source (
		output valid, msg_kind, mapped_valid, mapped_ip, mapped_port,
		       source_valid, source_attr_ip, source_attr_port,
		       changed_valid, changed_ip, changed_port, nat_verdict,
		input  ready
	);
	modport sink (
		input  valid, msg_kind, mapped_valid, mapped_ip, mapped_port,
		       source_valid, source_attr_ip, source_attr_port,
		       changed_valid, changed_ip, changed_port, nat_verdict,
		output ready
	);
endinterface

>>> design/stun_bp_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// STUN parser configuration registers
// Holds the server address that the verdict compares against.
// ----------------------------------------------------------------------------
module stun_bp_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [stun_bp_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [stun_bp_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output stun_bp_pkg::cfg_t                  cfg
);
	import stun_bp_pkg::*;

	logic [31:0] server_ip_q;
	logic [15:0] server_port_q;

	// Register writes, decoded by index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			server_ip_q   <= RESET_SERVER_IP;
			server_port_q <= RESET_SERVER_PORT;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_SERVER_IP: begin
					server_ip_q <= cfg_wdata[31:0];
				end
				REG_SERVER_PORT: begin
					server_port_q <= cfg_wdata[15:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg.server_ip   = server_ip_q;
	assign cfg.server_port = server_port_q;

endmodule

>>> design/stun_bp_parse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// STUN parser datapath
// Per-datagram state, header and attribute walk, capture and result logic.
// ----------------------------------------------------------------------------
module stun_bp_parse #(
	parameter int MAX_DATAGRAM_BYTES = stun_bp_pkg::DEFAULT_MAX_DATAGRAM_BYTES
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 proc_en,
	input  stun_bp_pkg::item_t   item,
	input  stun_bp_pkg::cfg_t    cfg,
	output stun_bp_pkg::result_t res
);
	import stun_bp_pkg::*;

	localparam int CNT_W = $clog2(MAX_DATAGRAM_BYTES + 1);

	// Per-datagram state.
	logic [CNT_W-1:0] byte_cnt_q, byte_cnt_n;
	logic [15:0]      msg_type_q, msg_type_n;
	logic [15:0]      attrs_len_q, attrs_len_n;
	logic [15:0]      attr_start_q, attr_start_n;
	logic [15:0]      attr_type_q, attr_type_n;
	logic [15:0]      attr_len_q, attr_len_n;
	logic [15:0]      port_sh_q, port_sh_n;
	logic [31:0]      ip_sh_q, ip_sh_n;
	logic [NUM_SLOTS-1:0] found_q, found_n;
	logic [15:0]      found_port_q [NUM_SLOTS];
	logic [15:0]      found_port_n [NUM_SLOTS];
	logic [31:0]      found_ip_q [NUM_SLOTS];
	logic [31:0]      found_ip_n [NUM_SLOTS];

	logic [15:0] rel;
	logic [15:0] off;
	logic [16:0] attr_end;
	logic [16:0] next_start;
	logic        kind_ok;

	// Next-state logic for one byte.
	always_comb begin
		byte_cnt_n   = byte_cnt_q;
		msg_type_n   = msg_type_q;
		attrs_len_n  = attrs_len_q;
		attr_start_n = attr_start_q;
		attr_type_n  = attr_type_q;
		attr_len_n   = attr_len_q;
		port_sh_n    = port_sh_q;
		ip_sh_n      = ip_sh_q;
		found_n      = found_q;
		found_port_n = found_port_q;
		found_ip_n   = found_ip_q;
		rel          = 16'(byte_cnt_q) - 16'(HDR_BYTES);
		off          = rel - attr_start_q;
		attr_end     = 17'd0;
		next_start   = 17'd0;

		if (byte_cnt_q < CNT_W'(MAX_DATAGRAM_BYTES)) begin
			byte_cnt_n = byte_cnt_q + CNT_W'(1);
			if (byte_cnt_q < CNT_W'(2)) begin
				msg_type_n = {msg_type_q[7:0], item.rx_byte};
			end else if (byte_cnt_q < CNT_W'(4)) begin
				attrs_len_n = {attrs_len_q[7:0], item.rx_byte};
			end else if (byte_cnt_q >= CNT_W'(HDR_BYTES) && msg_type_q == TYPE_SUCCESS
			             && attr_start_q < attrs_len_q && rel >= attr_start_q) begin
				// Field bytes at their offset inside the current attribute.
				if (off < 16'd2) begin
					attr_type_n = {attr_type_q[7:0], item.rx_byte};
				end else if (off == 16'd2) begin
					attr_len_n = {8'd0, item.rx_byte};
				end else if (off == 16'd3) begin
					attr_len_n = {attr_len_q[7:0], item.rx_byte};
				end else if (off == 16'd6 || off == 16'd7) begin
					port_sh_n = {port_sh_q[7:0], item.rx_byte};
				end else if (off >= 16'd8 && off <= 16'd11) begin
					ip_sh_n = {ip_sh_q[23:0], item.rx_byte};
				end

				// Last byte of the attribute: capture it if it is a known type of length 8 or more, and move to the next one.
				attr_end   = {1'b0, attr_len_n} + 17'd3;
				next_start = {1'b0, attr_start_q} + {1'b0, attr_len_n} + 17'd4;
				if (off >= 16'd3 && {1'b0, off} == attr_end) begin
					if (attr_len_n >= 16'd8) begin
						if (attr_type_n == ATTR_MAPPED) begin
							found_n[SLOT_MAPPED]      = 1'b1;
							found_port_n[SLOT_MAPPED] = port_sh_n;
							found_ip_n[SLOT_MAPPED]   = ip_sh_n;
						end else if (attr_type_n == ATTR_SOURCE) begin
							found_n[SLOT_SOURCE]      = 1'b1;
							found_port_n[SLOT_SOURCE] = port_sh_n;
							found_ip_n[SLOT_SOURCE]   = ip_sh_n;
						end else if (attr_type_n == ATTR_CHANGED) begin
							found_n[SLOT_CHANGED]      = 1'b1;
							found_port_n[SLOT_CHANGED] = port_sh_n;
							found_ip_n[SLOT_CHANGED]   = ip_sh_n;
						end
					end
					attr_start_n = next_start[16] ? 16'hFFFF : next_start[15:0];
				end
			end
		end
	end

	// Result for a datagram that ends with this byte.
	always_comb begin
		if (byte_cnt_n < CNT_W'(HDR_BYTES)) begin
			res.msg_kind = KIND_SHORT;
		end else if (msg_type_n == TYPE_SUCCESS) begin
			res.msg_kind = KIND_SUCCESS;
		end else if (msg_type_n == TYPE_ERROR) begin
			res.msg_kind = KIND_ERROR;
		end else begin
			res.msg_kind = KIND_OTHER;
		end
		kind_ok = (res.msg_kind == KIND_SUCCESS);

		res.mapped_valid     = kind_ok && found_n[SLOT_MAPPED];
		res.mapped_ip        = res.mapped_valid ? found_ip_n[SLOT_MAPPED] : 32'd0;
		res.mapped_port      = res.mapped_valid ? found_port_n[SLOT_MAPPED] : 16'd0;
		res.source_valid     = kind_ok && found_n[SLOT_SOURCE];
		res.source_attr_ip   = res.source_valid ? found_ip_n[SLOT_SOURCE] : 32'd0;
		res.source_attr_port = res.source_valid ? found_port_n[SLOT_SOURCE] : 16'd0;
		res.changed_valid    = kind_ok && found_n[SLOT_CHANGED];
		res.changed_ip       = res.changed_valid ? found_ip_n[SLOT_CHANGED] : 32'd0;
		res.changed_port     = res.changed_valid ? found_port_n[SLOT_CHANGED] : 16'd0;

		if (res.mapped_valid && item.sender_port != cfg.server_port) begin
			res.nat_verdict = (item.sender_ip != cfg.server_ip) ? VERDICT_FULL_CONE
			                                                    : VERDICT_RESTRICTED;
		end else begin
			res.nat_verdict = VERDICT_NONE;
		end
	end

	// State update; the final byte of a datagram clears everything.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_cnt_q   <= '0;
			msg_type_q   <= '0;
			attrs_len_q  <= '0;
			attr_start_q <= '0;
			attr_type_q  <= '0;
			attr_len_q   <= '0;
			port_sh_q    <= '0;
			ip_sh_q      <= '0;
			found_q      <= '0;
			for (int k = 0; k < NUM_SLOTS; k++) begin
				found_port_q[k] <= '0;
				found_ip_q[k]   <= '0;
			end
		end else if (proc_en) begin
			if (item.last_byte) begin
				byte_cnt_q   <= '0;
				msg_type_q   <= '0;
				attrs_len_q  <= '0;
				attr_start_q <= '0;
				attr_type_q  <= '0;
				attr_len_q   <= '0;
				port_sh_q    <= '0;
				ip_sh_q      <= '0;
				found_q      <= '0;
				for (int k = 0; k < NUM_SLOTS; k++) begin
					found_port_q[k] <= '0;
					found_ip_q[k]   <= '0;
				end
			end else begin
				byte_cnt_q   <= byte_cnt_n;
				msg_type_q   <= msg_type_n;
				attrs_len_q  <= attrs_len_n;
				attr_start_q <= attr_start_n;
				attr_type_q  <= attr_type_n;
				attr_len_q   <= attr_len_n;
				port_sh_q    <= port_sh_n;
				ip_sh_q      <= ip_sh_n;
				found_q      <= found_n;
				found_port_q <= found_port_n;
				found_ip_q   <= found_ip_n;
			end
		end
	end

endmodule

>>> design/stun_binding_response_parser_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// STUN binding response parser
// Parses a received datagram one byte at a time, captures the address
// attributes and reports message kind, addresses and a NAT verdict.
// ----------------------------------------------------------------------------
//  Channel  Direction  Transaction
//  din      sink       one datagram byte, last-byte mark, sender ip and port
//  dout     source     one parse result, after the last byte of a datagram
//  cfg      write      server ip (index 0) or server port (index 1)
//
// One byte is accepted per cycle unless a final byte waits for room on the
// output; each byte waits in the input register and is parsed by combinational
// logic against the datagram state. A result appears in the output register in
// the cycle after its last byte is parsed. While a result waits, non-final bytes
// keep flowing; a second final byte stalls only until the waiting result is taken.
// Reset loads the default server address and clears all datagram state.
// ----------------------------------------------------------------------------
module stun_binding_response_parser_core #(
	parameter int MAX_DATAGRAM_BYTES = stun_bp_pkg::DEFAULT_MAX_DATAGRAM_BYTES
) (
	input  logic                              clk,
	input  logic                              arst_n,
	stun_bp_in_if.sink                         din,
	stun_bp_out_if.source                      dout,
	input  logic                              cfg_we,
	input  logic [stun_bp_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [stun_bp_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import stun_bp_pkg::*;

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	logic    accept;
	logic    advance;
	result_t res;
	result_t res_q;
	logic    out_valid_q;

	stun_bp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// Handshake: a byte leaves the input register unless it is a final byte
	// whose result has no room.
	assign advance   = valid_s1 && (!item_s1.last_byte || !out_valid_q || dout.ready);
	assign din.ready = !valid_s1 || advance;
	assign accept    = din.valid && din.ready;

	// Input register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.rx_byte     <= din.rx_byte;
			item_s1.last_byte   <= din.last_byte;
			item_s1.sender_ip   <= din.sender_ip;
			item_s1.sender_port <= din.sender_port;
		end
	end

	stun_bp_parse #(
		.MAX_DATAGRAM_BYTES (MAX_DATAGRAM_BYTES)
	) u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.proc_en (advance),
		.item    (item_s1),
		.cfg     (cfg),
		.res     (res)
	);

	// Output register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && item_s1.last_byte) begin
			out_valid_q <= 1'b1;
		end else if (dout.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (advance && item_s1.last_byte) begin
			res_q <= res;
		end
	end

	assign dout.valid            = out_valid_q;
	assign dout.msg_kind         = res_q.msg_kind;
	assign dout.mapped_valid     = res_q.mapped_valid;
	assign dout.mapped_ip        = res_q.mapped_ip;
	assign dout.mapped_port      = res_q.mapped_port;
	assign dout.source_valid     = res_q.source_valid;
	assign dout.source_attr_ip   = res_q.source_attr_ip;
	assign dout.source_attr_port = res_q.source_attr_port;
	assign dout.changed_valid    = res_q.changed_valid;
	assign dout.changed_ip       = res_q.changed_ip;
	assign dout.changed_port     = res_q.changed_port;
	assign dout.nat_verdict      = res_q.nat_verdict;

	// A parsed final byte always puts a result on the output.
	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.last_byte |=> dout.valid)
		else $error("final byte parsed without a result");

	// The input stalls only behind a final byte whose result has no room.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!din.ready |-> valid_s1 && item_s1.last_byte && dout.valid && !dout.ready)
		else $error("input stalled without cause");

	// Only a binding success reports captured attributes or a verdict.
	a_kind_gates_fields: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid && dout.msg_kind != KIND_SUCCESS |->
			!dout.mapped_valid && !dout.source_valid && !dout.changed_valid
			&& dout.nat_verdict == VERDICT_NONE)
		else $error("fields reported for a non-success message");

	// A verdict needs a mapped address.
	a_verdict_needs_mapped: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid && dout.nat_verdict != VERDICT_NONE |-> dout.mapped_valid)
		else $error("verdict without a mapped address");

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// STUN binding response parser testbench
// Sends whole datagrams byte by byte into the parser and predicts each result
// from its own copy of the parse state. Directed datagrams cover the header
// kinds, the attribute capture rules, the NAT verdicts, the server address
// extremes and an oversize datagram. Random traffic then runs in phases with
// and without idle cycles on the byte channel and stalls on the result
// channel.
// ----------------------------------------------------------------------------
module tb_top;
	import stun_bp_pkg::*;

	localparam int CLK_PERIOD    = 10;
	localparam int RESET_CYCLES  = 11;
	localparam int SETTLE_CYCLES = 8;
	localparam int TIMEOUT_NS    = 10_000_000;
	localparam int MAX_BYTES     = DEFAULT_MAX_DATAGRAM_BYTES;
	localparam int RANDOM_BYTES  = 700;
	localparam int PHASE_DGRAMS  = 12;

	// How the sender of a datagram relates to the configured server.
	localparam int REL_SAME      = 0;
	localparam int REL_PORT_ONLY = 1;
	localparam int REL_BOTH      = 2;
	localparam int REL_IP_ONLY   = 3;
	localparam int REL_ANY       = 4;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	stun_bp_in_if  din_if ();
	stun_bp_out_if dout_if ();

	stun_binding_response_parser_core #(
		.MAX_DATAGRAM_BYTES(MAX_BYTES)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.din      (din_if),
		.dout     (dout_if),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Server address as the block should hold it.
	logic [31:0] srv_ip;
	logic [15:0] srv_port;

	// Per-datagram parse state of the prediction.
	logic [15:0] byte_count;
	logic [15:0] msg_type;
	logic [15:0] area_len;
	logic [15:0] attr_base;
	logic [15:0] attr_type;
	logic [15:0] attr_len;
	logic [15:0] port_acc;
	logic [31:0] ip_acc;
	logic [2:0]  found;
	logic [15:0] found_port [NUM_SLOTS];
	logic [31:0] found_ip   [NUM_SLOTS];

	result_t     pending_reports [$];
	logic [7:0]  pkt [$];

	int send_idle_pct  = 0;
	int sink_stall_pct = 0;
	int mismatches     = 0;
	int bytes_sent     = 0;
	int dgrams_sent    = 0;
	int results_seen   = 0;
	int kind_seen [4]    = '{default: 0};
	int verdict_seen [3] = '{default: 0};

	// Clear everything that belongs to one datagram.
	task automatic clear_parse_state();
		byte_count = '0;
		msg_type   = '0;
		area_len   = '0;
		attr_base  = '0;
		attr_type  = '0;
		attr_len   = '0;
		port_acc   = '0;
		ip_acc     = '0;
		found      = '0;
		for (int k = 0; k < NUM_SLOTS; k++) begin
			found_port[k] = '0;
			found_ip[k]   = '0;
		end
	endtask

	// Advance the parse by one accepted byte; a final byte yields a report.
	task automatic parse_rx_byte(input logic [7:0] b, input logic last,
			input logic [31:0] sip, input logic [15:0] sport);
		result_t rpt;
		int pos;
		int off;
		int next_start;
		int slot;
		pos = int'(byte_count);
		if (pos < MAX_BYTES) begin
			if (pos < 2) begin
				msg_type = {msg_type[7:0], b};
			end else if (pos < 4) begin
				area_len = {area_len[7:0], b};
			end else if (pos >= HDR_BYTES && msg_type == TYPE_SUCCESS &&
					attr_base < area_len && pos - HDR_BYTES >= int'(attr_base)) begin
				off = pos - HDR_BYTES - int'(attr_base);
				if (off < 2)
					attr_type = {attr_type[7:0], b};
				else if (off == 2)
					attr_len = {8'h00, b};
				else if (off == 3)
					attr_len = {attr_len[7:0], b};
				else if (off == 6 || off == 7)
					port_acc = {port_acc[7:0], b};
				else if (off >= 8 && off <= 11)
					ip_acc = {ip_acc[23:0], b};
				// The last byte of an attribute commits it and moves to the next.
				if (off >= 3 && off == int'(attr_len) + 3) begin
					next_start = int'(attr_base) + int'(attr_len) + 4;
					if (attr_len >= 16'd8) begin
						case (attr_type)
							ATTR_MAPPED:  slot = SLOT_MAPPED;
							ATTR_SOURCE:  slot = SLOT_SOURCE;
							ATTR_CHANGED: slot = SLOT_CHANGED;
							default:      slot = -1;
						endcase
						if (slot >= 0) begin
							found_port[slot] = port_acc;
							found_ip[slot]   = ip_acc;
							found[slot]      = 1'b1;
						end
					end
					attr_base = (next_start > 16'hFFFF) ? 16'hFFFF : next_start[15:0];
				end
			end
			byte_count = byte_count + 16'd1;
		end
		if (last) begin
			rpt = '0;
			if (byte_count < HDR_BYTES)
				rpt.msg_kind = KIND_SHORT;
			else if (msg_type == TYPE_SUCCESS)
				rpt.msg_kind = KIND_SUCCESS;
			else if (msg_type == TYPE_ERROR)
				rpt.msg_kind = KIND_ERROR;
			else
				rpt.msg_kind = KIND_OTHER;
			if (rpt.msg_kind == KIND_SUCCESS) begin
				if (found[SLOT_MAPPED]) begin
					rpt.mapped_valid = 1'b1;
					rpt.mapped_ip    = found_ip[SLOT_MAPPED];
					rpt.mapped_port  = found_port[SLOT_MAPPED];
					if (sport != srv_port)
						rpt.nat_verdict = (sip != srv_ip) ? VERDICT_FULL_CONE : VERDICT_RESTRICTED;
				end
				if (found[SLOT_SOURCE]) begin
					rpt.source_valid     = 1'b1;
					rpt.source_attr_ip   = found_ip[SLOT_SOURCE];
					rpt.source_attr_port = found_port[SLOT_SOURCE];
				end
				if (found[SLOT_CHANGED]) begin
					rpt.changed_valid = 1'b1;
					rpt.changed_ip    = found_ip[SLOT_CHANGED];
					rpt.changed_port  = found_port[SLOT_CHANGED];
				end
			end
			kind_seen[rpt.msg_kind]++;
			verdict_seen[rpt.nat_verdict]++;
			pending_reports.push_back(rpt);
			clear_parse_state();
		end
	endtask

	// Offer one byte and hold it until the parser takes it.
	task automatic send_byte(input logic [7:0] b, input logic last,
			input logic [31:0] ip, input logic [15:0] port);
		if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
			din_if.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
		din_if.valid       <= 1'b1;
		din_if.rx_byte     <= b;
		din_if.last_byte   <= last;
		din_if.sender_ip   <= ip;
		din_if.sender_port <= port;
		@(posedge clk);
		while (din_if.ready !== 1'b1) @(posedge clk);
		bytes_sent++;
		parse_rx_byte(b, last, ip, port);
	endtask

	// Send the datagram in pkt; the final byte always carries the real sender, other bytes carry it or a random one.
	task automatic send_msg(input logic [31:0] ip, input logic [15:0] port);
		logic last;
		logic [31:0] bip;
		logic [15:0] bport;
		for (int i = 0; i < pkt.size(); i++) begin
			last = (i == pkt.size() - 1);
			if (last || $urandom_range(0, 1)) begin
				bip   = ip;
				bport = port;
			end else begin
				bip   = $urandom();
				bport = 16'($urandom_range(0, 65535));
			end
			send_byte(pkt[i], last, bip, bport);
		end
		dgrams_sent++;
	endtask

	// Pick a sender address with the given relation to the server.
	function automatic logic [47:0] sender_for(input int rel);
		logic [31:0] ip;
		logic [15:0] port;
		logic [31:0] flip_ip;
		logic [15:0] flip_port;
		flip_ip = $urandom();
		if (flip_ip == 32'h0)
			flip_ip = 32'h1;
		flip_port = 16'($urandom_range(1, 65535));
		case (rel)
			REL_SAME: begin
				ip   = srv_ip;
				port = srv_port;
			end
			REL_PORT_ONLY: begin
				ip   = srv_ip;
				port = srv_port ^ flip_port;
			end
			REL_BOTH: begin
				ip   = srv_ip ^ flip_ip;
				port = srv_port ^ flip_port;
			end
			REL_IP_ONLY: begin
				ip   = srv_ip ^ flip_ip;
				port = srv_port;
			end
			default: begin
				ip   = $urandom();
				port = 16'($urandom_range(0, 65535));
			end
		endcase
		return {ip, port};
	endfunction

	task automatic send_from(input int rel);
		logic [47:0] who;
		who = sender_for(rel);
		send_msg(who[47:16], who[15:0]);
	endtask

	// Start a new datagram with a header of the given type and a random ID.
	task automatic begin_msg(input logic [15:0] mtype);
		pkt.delete();
		pkt.push_back(mtype[15:8]);
		pkt.push_back(mtype[7:0]);
		pkt.push_back(8'h00);
		pkt.push_back(8'h00);
		repeat (HDR_BYTES - 4) pkt.push_back(8'($urandom_range(0, 255)));
	endtask

	// Append one attribute laid out as an IPv4 address value.
	task automatic add_attr(input logic [15:0] atype, input int len,
			input logic [15:0] port, input logic [31:0] ip);
		logic [15:0] alen;
		alen = len[15:0];
		pkt.push_back(atype[15:8]);
		pkt.push_back(atype[7:0]);
		pkt.push_back(alen[15:8]);
		pkt.push_back(alen[7:0]);
		for (int k = 0; k < len; k++) begin
			case (k)
				1:       pkt.push_back(8'h01);
				2:       pkt.push_back(port[15:8]);
				3:       pkt.push_back(port[7:0]);
				4:       pkt.push_back(ip[31:24]);
				5:       pkt.push_back(ip[23:16]);
				6:       pkt.push_back(ip[15:8]);
				7:       pkt.push_back(ip[7:0]);
				default: pkt.push_back(8'($urandom_range(0, 255)));
			endcase
		end
	endtask

	// Write an attribute area length into the header.
	task automatic set_area_len(input int len);
		logic [15:0] l16;
		l16 = len[15:0];
		pkt[2] = l16[15:8];
		pkt[3] = l16[7:0];
	endtask

	// Stop offering bytes and wait until every report has come back.
	task automatic wait_idle();
		if (din_if.valid !== 1'b0)
			din_if.valid <= 1'b0;
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Load both server registers while the parser is idle.
	task automatic set_server(input logic [31:0] ip, input logic [15:0] port);
		logic [15:0] junk;
		junk = 16'($urandom_range(0, 65535));
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_idx   <= REG_SERVER_IP;
		cfg_wdata <= ip;
		@(posedge clk);
		srv_ip = ip;
		cfg_idx   <= REG_SERVER_PORT;
		cfg_wdata <= {junk, port};
		@(posedge clk);
		srv_port = port;
		cfg_we <= 1'b0;
	endtask

	// Build and send one random datagram, mostly well-formed responses.
	task automatic send_random_datagram();
		int pick;
		int alen;
		logic [15:0] atype;
		pick = $urandom_range(0, 99);
		if (pick < 15) begin
			// Too short for a header.
			pkt.delete();
			repeat ($urandom_range(1, HDR_BYTES - 1)) pkt.push_back(8'($urandom_range(0, 255)));
			if (pkt.size() >= 2 && $urandom_range(0, 1)) begin
				pkt[0] = TYPE_SUCCESS[15:8];
				pkt[1] = TYPE_SUCCESS[7:0];
			end
		end else if (pick < 20) begin
			pkt.delete();
			repeat ($urandom_range(HDR_BYTES, 48)) pkt.push_back(8'($urandom_range(0, 255)));
		end else begin
			if (pick < 30)
				begin_msg(TYPE_ERROR);
			else if (pick < 38)
				begin_msg(16'($urandom_range(0, 65535)));
			else
				begin_msg(TYPE_SUCCESS);
			repeat ($urandom_range(0, 4)) begin
				case ($urandom_range(0, 4))
					0, 1:    atype = ATTR_MAPPED;
					2:       atype = ATTR_SOURCE;
					3:       atype = ATTR_CHANGED;
					default: atype = 16'($urandom_range(0, 65535));
				endcase
				alen = ($urandom_range(0, 9) < 7) ? 8 : $urandom_range(0, 16);
				add_attr(atype, alen, 16'($urandom_range(0, 65535)), $urandom());
			end
			set_area_len(pkt.size() - HDR_BYTES);
			// Some headers claim a wrong length, some datagrams end early.
			if ($urandom_range(0, 99) < 15)
				set_area_len($urandom_range(0, pkt.size()));
			if ($urandom_range(0, 99) < 10 && pkt.size() > HDR_BYTES + 1)
				repeat ($urandom_range(1, pkt.size() - HDR_BYTES - 1)) pkt.pop_back();
		end
		send_from($urandom_range(REL_SAME, REL_ANY));
	endtask

	task automatic run_traffic_phase(input int idle_pct, input int stall_pct);
		int start_bytes;
		int start_dgrams;
		send_idle_pct  = idle_pct;
		sink_stall_pct = stall_pct;
		start_bytes    = bytes_sent;
		start_dgrams   = dgrams_sent;
		while (bytes_sent - start_bytes < RANDOM_BYTES / 4 ||
				dgrams_sent - start_dgrams < PHASE_DGRAMS)
			send_random_datagram();
		wait_idle();
	endtask

	// Datagrams that end before or exactly at the end of the header.
	task automatic test_short_datagrams();
		pkt.delete();
		pkt.push_back(8'hFF);
		send_from(REL_BOTH);
		begin_msg(TYPE_SUCCESS);
		void'(pkt.pop_back());
		send_from(REL_BOTH);
		begin_msg(TYPE_SUCCESS);
		send_from(REL_BOTH);
		wait_idle();
	endtask

	// Error and other message types carry attributes that are never walked.
	task automatic test_message_kinds();
		begin_msg(TYPE_ERROR);
		add_attr(ATTR_MAPPED, 8, 16'($urandom_range(0, 65535)), $urandom());
		set_area_len(pkt.size() - HDR_BYTES);
		send_from(REL_BOTH);
		begin_msg(16'hFFFF);
		add_attr(ATTR_MAPPED, 8, 16'($urandom_range(0, 65535)), $urandom());
		set_area_len(pkt.size() - HDR_BYTES);
		send_from(REL_BOTH);
		begin_msg(16'h0000);
		send_from(REL_ANY);
		wait_idle();
	endtask

	// Capture rules: length limits, unknown types, repeats and truncation.
	task automatic test_attribute_capture();
		// Unknown and undersized attributes are skipped; a repeat replaces.
		begin_msg(TYPE_SUCCESS);
		add_attr(16'h8001, 8, 16'($urandom_range(0, 65535)), $urandom());
		add_attr(ATTR_MAPPED, 4, 16'($urandom_range(0, 65535)), $urandom());
		add_attr(ATTR_MAPPED, 8, 16'hFFFF, 32'hFFFF_FFFF);
		add_attr(ATTR_SOURCE, 8, 16'h0000, 32'h0000_0000);
		add_attr(ATTR_CHANGED, 12, 16'($urandom_range(0, 65535)), $urandom());
		add_attr(ATTR_MAPPED, 8, 16'h1234, $urandom());
		set_area_len(pkt.size() - HDR_BYTES);
		send_from(REL_BOTH);
		// Attributes of length zero and two before a capture.
		begin_msg(TYPE_SUCCESS);
		add_attr(ATTR_SOURCE, 0, 16'h0, 32'h0);
		add_attr(ATTR_CHANGED, 2, 16'h0, 32'h0);
		add_attr(ATTR_MAPPED, 8, 16'($urandom_range(0, 65535)), $urandom());
		set_area_len(pkt.size() - HDR_BYTES);
		send_from(REL_PORT_ONLY);
		// The header length covers only the first attribute.
		begin_msg(TYPE_SUCCESS);
		add_attr(ATTR_MAPPED, 8, 16'($urandom_range(0, 65535)), $urandom());
		add_attr(ATTR_SOURCE, 8, 16'($urandom_range(0, 65535)), $urandom());
		set_area_len(12);
		send_from(REL_BOTH);
		// The datagram ends inside the mapped address attribute.
		begin_msg(TYPE_SUCCESS);
		add_attr(ATTR_CHANGED, 8, 16'($urandom_range(0, 65535)), $urandom());
		add_attr(ATTR_MAPPED, 12, 16'($urandom_range(0, 65535)), $urandom());
		set_area_len(pkt.size() - HDR_BYTES);
		repeat (5) void'(pkt.pop_back());
		send_from(REL_BOTH);
		wait_idle();
	endtask

	// Every sender relation against the reset server address.
	task automatic test_nat_verdicts();
		for (int rel = REL_SAME; rel <= REL_IP_ONLY; rel++) begin
			begin_msg(TYPE_SUCCESS);
			add_attr(ATTR_MAPPED, 8, 16'($urandom_range(0, 65535)), $urandom());
			set_area_len(pkt.size() - HDR_BYTES);
			send_from(rel);
		end
		// No verdict without a mapped address.
		begin_msg(TYPE_SUCCESS);
		add_attr(ATTR_SOURCE, 8, 16'($urandom_range(0, 65535)), $urandom());
		set_area_len(pkt.size() - HDR_BYTES);
		send_from(REL_BOTH);
		wait_idle();
	endtask

	// Verdicts with the server address at all zeros and at all ones.
	task automatic test_config_extremes();
		set_server(32'h0000_0000, 16'h0000);
		for (int rel = REL_SAME; rel <= REL_IP_ONLY; rel++) begin
			begin_msg(TYPE_SUCCESS);
			add_attr(ATTR_MAPPED, 8, 16'($urandom_range(0, 65535)), $urandom());
			set_area_len(pkt.size() - HDR_BYTES);
			send_from(rel);
		end
		set_server(32'hFFFF_FFFF, 16'hFFFF);
		for (int rel = REL_SAME; rel <= REL_IP_ONLY; rel++) begin
			begin_msg(TYPE_SUCCESS);
			add_attr(ATTR_MAPPED, 8, 16'($urandom_range(0, 65535)), $urandom());
			set_area_len(pkt.size() - HDR_BYTES);
			send_from(rel);
		end
		wait_idle();
	endtask

	// An attribute that straddles the byte limit is lost; the report still comes.
	task automatic test_oversize_datagram();
		begin_msg(TYPE_SUCCESS);
		add_attr(ATTR_MAPPED, 8, 16'($urandom_range(0, 65535)), $urandom());
		add_attr(16'h0020, 2004, 16'($urandom_range(0, 65535)), $urandom());
		add_attr(ATTR_SOURCE, 8, 16'($urandom_range(0, 65535)), $urandom());
		set_area_len(pkt.size() - HDR_BYTES);
		while (pkt.size() < MAX_BYTES + 12) pkt.push_back(8'($urandom_range(0, 255)));
		send_from(REL_BOTH);
		wait_idle();
	endtask

	task automatic test_random_traffic();
		set_server(RESET_SERVER_IP, RESET_SERVER_PORT);
		run_traffic_phase(0, 0);
		set_server($urandom(), 16'($urandom_range(0, 65535)));
		run_traffic_phase(54, 0);
		set_server($urandom(), 16'($urandom_range(0, 65535)));
		run_traffic_phase(0, 54);
		set_server($urandom(), 16'($urandom_range(0, 65535)));
		run_traffic_phase(22, 22);
	endtask

	// The result channel stalls at the rate of the current phase.
	always @(posedge clk)
		dout_if.ready <= ($urandom_range(0, 99) >= sink_stall_pct);

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endtask

	// Compare each result transaction with the oldest pending report.
	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n === 1'b1 && dout_if.valid === 1'b1 && dout_if.ready === 1'b1) begin
			results_seen++;
			if (pending_reports.size() == 0) begin
				$error("result transaction with no datagram pending");
				mismatches++;
			end else begin
				want = pending_reports.pop_front();
				check_field("msg_kind", 32'(want.msg_kind), 32'(dout_if.msg_kind));
				check_field("mapped_valid", 32'(want.mapped_valid),
					32'(dout_if.mapped_valid));
				check_field("mapped_ip", want.mapped_ip, dout_if.mapped_ip);
				check_field("mapped_port", 32'(want.mapped_port), 32'(dout_if.mapped_port));
				check_field("source_valid", 32'(want.source_valid),
					32'(dout_if.source_valid));
				check_field("source_attr_ip", want.source_attr_ip, dout_if.source_attr_ip);
				check_field("source_attr_port", 32'(want.source_attr_port),
					32'(dout_if.source_attr_port));
				check_field("changed_valid", 32'(want.changed_valid),
					32'(dout_if.changed_valid));
				check_field("changed_ip", want.changed_ip, dout_if.changed_ip);
				check_field("changed_port", 32'(want.changed_port),
					32'(dout_if.changed_port));
				check_field("nat_verdict", 32'(want.nat_verdict), 32'(dout_if.nat_verdict));
			end
		end
	end

	initial begin
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_idx            = REG_SERVER_IP;
		cfg_wdata          = '0;
		din_if.valid       = 1'b0;
		din_if.rx_byte     = '0;
		din_if.last_byte   = 1'b0;
		din_if.sender_ip   = '0;
		din_if.sender_port = '0;
		srv_ip             = RESET_SERVER_IP;
		srv_port           = RESET_SERVER_PORT;
		clear_parse_state();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_short_datagrams();
		test_message_kinds();
		test_attribute_capture();
		test_nat_verdicts();
		test_config_extremes();
		test_oversize_datagram();
		test_random_traffic();
		wait_idle();

		$display("Sent %0d datagrams in %0d bytes: %0d success, %0d error, %0d other, %0d short.",
			dgrams_sent, bytes_sent, kind_seen[KIND_SUCCESS], kind_seen[KIND_ERROR],
			kind_seen[KIND_OTHER], kind_seen[KIND_SHORT]);
		$display("Checked %0d reports; verdicts: %0d none, %0d full cone, %0d restricted.",
			results_seen, verdict_seen[VERDICT_NONE], verdict_seen[VERDICT_FULL_CONE],
			verdict_seen[VERDICT_RESTRICTED]);
		if (mismatches == 0 && pending_reports.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#(TIMEOUT_NS);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

>>> stun_binding_response_parser_core.f
design/stun_bp_pkg.sv
design/stun_bp_in_if.sv
design/stun_bp_out_if.sv
design/stun_bp_cfg.sv
design/stun_bp_parse.sv
design/stun_binding_response_parser_core.sv
tb/sv/tb_top.sv
